// ----- hw/rtl/hidkm_pkg.sv -----
// Shared types, constants and lookup functions for the HID report to key matrix block.
// Used by the matrix builder, the top level and the testbench.
// No dependencies.
`default_nettype none

package hidkm_pkg;

   localparam int MATRIX_ROWS = 8;
   localparam int MATRIX_COLS = 5;
   localparam int KEY_SLOTS   = 6;

   typedef logic [MATRIX_COLS-1:0]           row_type;
   typedef row_type [MATRIX_ROWS-1:0]        matrix_type;

   typedef enum logic [1:0] {
      REQ_REPORT = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_READ   = 2'd2,
      REQ_TYPE   = 2'd3
   } req_kind_type;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FRAMES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_FRAMES  = 1'd1;
   localparam logic [3:0] HOLD_FRAMES_RESET = 4'd4;
   localparam logic [3:0] GAP_FRAMES_RESET  = 4'd3;

   localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
   localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
   localparam logic [7:0] MOD_LEFT_SHIFT = 8'h02;
   localparam logic [4:0] ROW_IDLE       = 5'h1F;

   // ROM entry: bits 5:0 are row*8+bit (zero means no key), bit 6 adds Caps
   // Shift and bit 7 adds Symbol Shift.
   localparam logic [5:0] KEY_CAPS = 6'o00;
   localparam logic [5:0] KEY_SYM  = 6'o71;
   localparam int ENTRY_CAPS_BIT = 6;
   localparam int ENTRY_SYM_BIT  = 7;

   typedef struct packed {
      logic [7:0]                modifiers;
      logic [KEY_SLOTS-1:0][7:0] usages;
   } held_type;

   typedef struct packed {
      logic       ok;
      logic       shift;
      logic [6:0] usage;
   } char_map_type;

   function automatic logic [7:0] rk(input logic [2:0] row, input logic [2:0] col);
      rk = {2'b00, row, col};
   endfunction

   function automatic logic [7:0] usage_rom(input logic [7:0] usage);
      logic [7:0] caps;
      logic [7:0] sym;
      caps = 8'h40;
      sym  = 8'h80;
      unique case (usage)
         8'h04: usage_rom = rk(3'd1, 3'd0);
         8'h05: usage_rom = rk(3'd7, 3'd4);
         8'h06: usage_rom = rk(3'd0, 3'd3);
         8'h07: usage_rom = rk(3'd1, 3'd2);
         8'h08: usage_rom = rk(3'd2, 3'd2);
         8'h09: usage_rom = rk(3'd1, 3'd3);
         8'h0A: usage_rom = rk(3'd1, 3'd4);
         8'h0B: usage_rom = rk(3'd6, 3'd4);
         8'h0C: usage_rom = rk(3'd5, 3'd2);
         8'h0D: usage_rom = rk(3'd6, 3'd3);
         8'h0E: usage_rom = rk(3'd6, 3'd2);
         8'h0F: usage_rom = rk(3'd6, 3'd1);
         8'h10: usage_rom = rk(3'd7, 3'd2);
         8'h11: usage_rom = rk(3'd7, 3'd3);
         8'h12: usage_rom = rk(3'd5, 3'd1);
         8'h13: usage_rom = rk(3'd5, 3'd0);
         8'h14: usage_rom = rk(3'd2, 3'd0);
         8'h15: usage_rom = rk(3'd2, 3'd3);
         8'h16: usage_rom = rk(3'd1, 3'd1);
         8'h17: usage_rom = rk(3'd2, 3'd4);
         8'h18: usage_rom = rk(3'd5, 3'd3);
         8'h19: usage_rom = rk(3'd0, 3'd4);
         8'h1A: usage_rom = rk(3'd2, 3'd1);
         8'h1B: usage_rom = rk(3'd0, 3'd2);
         8'h1C: usage_rom = rk(3'd5, 3'd4);
         8'h1D: usage_rom = rk(3'd0, 3'd1);
         8'h1E: usage_rom = rk(3'd3, 3'd0);
         8'h1F: usage_rom = rk(3'd3, 3'd1);
         8'h20: usage_rom = rk(3'd3, 3'd2);
         8'h21: usage_rom = rk(3'd3, 3'd3);
         8'h22: usage_rom = rk(3'd3, 3'd4);
         8'h23: usage_rom = rk(3'd4, 3'd4);
         8'h24: usage_rom = rk(3'd4, 3'd3);
         8'h25: usage_rom = rk(3'd4, 3'd2);
         8'h26: usage_rom = rk(3'd4, 3'd1);
         8'h27: usage_rom = rk(3'd4, 3'd0);
         8'h28: usage_rom = rk(3'd6, 3'd0);
         8'h2C: usage_rom = rk(3'd7, 3'd0);
         8'h2A: usage_rom = rk(3'd4, 3'd0) | caps;
         8'h4C: usage_rom = rk(3'd4, 3'd0) | caps;
         8'h50: usage_rom = rk(3'd3, 3'd4) | caps;
         8'h51: usage_rom = rk(3'd4, 3'd4) | caps;
         8'h52: usage_rom = rk(3'd4, 3'd3) | caps;
         8'h4F: usage_rom = rk(3'd4, 3'd2) | caps;
         8'h29: usage_rom = rk(3'd7, 3'd0) | caps;
         8'h33: usage_rom = rk(3'd5, 3'd1) | sym;
         8'h34: usage_rom = rk(3'd4, 3'd3) | sym;
         8'h36: usage_rom = rk(3'd7, 3'd3) | sym;
         8'h37: usage_rom = rk(3'd7, 3'd2) | sym;
         8'h38: usage_rom = rk(3'd0, 3'd4) | sym;
         8'h2D: usage_rom = rk(3'd6, 3'd3) | sym;
         8'h2E: usage_rom = rk(3'd6, 3'd1) | sym;
         default: usage_rom = 8'h00;
      endcase
   endfunction

   // Maps a typed ASCII character to a HID usage, with Caps Shift for capitals.
   function automatic char_map_type char_to_usage(input logic [7:0] c);
      char_map_type m;
      logic [7:0]   u;
      m = '0;
      u = 8'h00;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'h5D;
         m.ok = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         u = c - 8'h3D;
         m.ok = 1'b1;
         m.shift = 1'b1;
      end else if (c >= 8'h31 && c <= 8'h39) begin
         u = c - 8'h13;
         m.ok = 1'b1;
      end else begin
         m.ok = 1'b1;
         unique case (c)
            8'h30: u = 8'h27;
            8'h20: u = 8'h2C;
            8'h0A: u = 8'h28;
            8'h3B: u = 8'h33;
            8'h27: u = 8'h34;
            8'h2C: u = 8'h36;
            8'h2E: u = 8'h37;
            8'h2F: u = 8'h38;
            8'h2D: u = 8'h2D;
            8'h3D: u = 8'h2E;
            default: m.ok = 1'b0;
         endcase
      end
      m.usage = u[6:0];
      char_to_usage = m;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hidkm_channels.sv -----
// Valid/ready channel interfaces for the request and response sides.
// No package dependencies; the six key slots are declared as separate fields.
`default_nettype none

interface hidkm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;
   logic [7:0] high_addr;
   logic [7:0] char_code;

   modport source (
      output valid, req_type, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5, high_addr, char_code,
      input  ready
   );
   modport sink (
      input  valid, req_type, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5, high_addr, char_code,
      output ready
   );
endinterface

interface hidkm_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] read_data;
   logic       char_accepted;
   logic       typing_busy;

   modport source (
      output valid, read_data, char_accepted, typing_busy,
      input  ready
   );
   modport sink (
      input  valid, read_data, char_accepted, typing_busy,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/hidkm_matrix_build.sv -----
// Combinational matrix builder: held modifiers and six usages to eight active-low rows.
// Depends on hidkm_pkg for the usage ROM and the held-key struct.
`default_nettype none

module hidkm_matrix_build (
   input  hidkm_pkg::held_type   held,
   output hidkm_pkg::matrix_type rows
);

   logic [hidkm_pkg::KEY_SLOTS-1:0][7:0] entry;
   logic [63:0]                          down;

   always_comb begin
      for (int i = 0; i < hidkm_pkg::KEY_SLOTS; i++) begin
         entry[i] = hidkm_pkg::usage_rom(held.usages[i]);
      end
   end

   // One pressed flag per row*8+bit position; columns 5 to 7 never get set.
   always_comb begin
      down = '0;
      if ((held.modifiers & hidkm_pkg::MOD_SHIFT_MASK) != 8'h00) begin
         down[hidkm_pkg::KEY_CAPS] = 1'b1;
      end
      if ((held.modifiers & hidkm_pkg::MOD_CTRL_MASK) != 8'h00) begin
         down[hidkm_pkg::KEY_SYM] = 1'b1;
      end
      for (int i = 0; i < hidkm_pkg::KEY_SLOTS; i++) begin
         if (entry[i][5:0] != 6'd0) begin
            down[entry[i][5:0]] = 1'b1;
            if (entry[i][hidkm_pkg::ENTRY_CAPS_BIT]) begin
               down[hidkm_pkg::KEY_CAPS] = 1'b1;
            end
            if (entry[i][hidkm_pkg::ENTRY_SYM_BIT]) begin
               down[hidkm_pkg::KEY_SYM] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < hidkm_pkg::MATRIX_ROWS; r++) begin
         for (int b = 0; b < hidkm_pkg::MATRIX_COLS; b++) begin
            rows[r][b] = ~down[r*8 + b];
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hid_report_to_key_matrix.sv -----
// HID boot keyboard report to 8x5 active-low key matrix, with a typed-character queue.
// Depends on hidkm_pkg, the channel interfaces and hidkm_matrix_build.
//
// Usage: each request transaction on req_ch carries a kind in req_type: a keyboard
// report (stored only), a frame tick (advances typing and rebuilds the matrix), a
// port read (ANDs the rows whose high_addr bit is zero) or a character to type.
// Every request yields exactly one response transaction on rsp_ch with read_data
// (31 unless a port read), char_accepted and typing_busy.
// A request is registered in the input register on acceptance and executed from
// there once the response register is empty or being taken; its response is then
// held in the response register. One request per cycle is sustained while the
// receiver takes every response; the path from the input register through the six
// usage ROM lookups into the row registers sets the cycle time.
// Typed characters sit in a QUEUE_DEPTH entry memory that holds at most
// QUEUE_DEPTH-1 characters; the entry at the head is kept in a read register.
// When the receiver stalls, the response register holds and one more request
// is still taken into the input register; after that req_ch.ready drops.
// Synchronous reset releases all keys, empties the queue and restores the
// hold and gap frame counts to 4 and 3. No clearing pass is needed.
// The csr_ port writes hold_frames (index 0) and gap_frames (index 1).
`default_nettype none

module hid_report_to_key_matrix #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   hidkm_req_if.sink                         req_ch,
   hidkm_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [hidkm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hidkm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // Input register.
   logic                                  in_valid_ff;
   hidkm_pkg::req_kind_type               in_kind_ff;
   logic [7:0]                            in_mod_ff;
   logic [hidkm_pkg::KEY_SLOTS-1:0][7:0]  in_slots_ff;
   logic [7:0]                            in_addr_ff;
   logic [7:0]                            in_char_ff;

   // Block state.
   logic [3:0]                hold_ff;
   logic [3:0]                gap_ff;
   hidkm_pkg::matrix_type     rows_ff;
   hidkm_pkg::held_type       held_ff;
   hidkm_pkg::held_type       held_in;
   logic [PTR_W-1:0]          head_ff;
   logic [PTR_W-1:0]          head_in;
   logic [PTR_W-1:0]          tail_ff;
   logic [PTR_W-1:0]          tail_in;
   logic [3:0]                phase_ff;
   logic [3:0]                phase_in;
   logic                      down_ff;
   logic                      down_in;

   logic [7:0]                queue_mem [QUEUE_DEPTH];
   logic [7:0]                head_data_ff;

   // Response register.
   logic                      rsp_valid_ff;
   logic [4:0]                read_data_ff;
   logic                      accepted_ff;
   logic                      busy_ff;

   logic                      exec;
   logic                      busy_now;
   logic [3:0]                phase_dec;
   logic [PTR_W-1:0]          head_inc;
   logic [PTR_W-1:0]          tail_inc;
   hidkm_pkg::char_map_type   char_map;
   logic                      q_write;
   logic [7:0]                q_wdata;
   hidkm_pkg::held_type       build_held;
   hidkm_pkg::matrix_type     build_rows;
   logic [4:0]                read_and;
   logic                      accepted;

   assign exec         = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff     <= hidkm_pkg::req_kind_type'(req_ch.req_type);
         in_mod_ff      <= req_ch.modifier_bits;
         in_slots_ff[0] <= req_ch.key_slot_0;
         in_slots_ff[1] <= req_ch.key_slot_1;
         in_slots_ff[2] <= req_ch.key_slot_2;
         in_slots_ff[3] <= req_ch.key_slot_3;
         in_slots_ff[4] <= req_ch.key_slot_4;
         in_slots_ff[5] <= req_ch.key_slot_5;
         in_addr_ff     <= req_ch.high_addr;
         in_char_ff     <= req_ch.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= hidkm_pkg::HOLD_FRAMES_RESET;
         gap_ff  <= hidkm_pkg::GAP_FRAMES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hidkm_pkg::CSR_HOLD_FRAMES: hold_ff <= csr_wdata;
            hidkm_pkg::CSR_GAP_FRAMES:  gap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy_now  = (head_ff != tail_ff) || down_ff;
   assign phase_dec = (phase_ff != 4'd0) ? phase_ff - 4'd1 : 4'd0;
   assign head_inc  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_inc  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign char_map  = hidkm_pkg::char_to_usage(in_char_ff);
   assign q_write   = exec && (in_kind_ff == hidkm_pkg::REQ_TYPE) && char_map.ok
                      && (tail_inc != head_ff);
   assign q_wdata   = {char_map.shift, char_map.usage};

   // Typing sequencer and held-report update. The entry replayed while a typed
   // key is down is always the one at the current head, which head_data_ff holds.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      phase_in   = phase_ff;
      down_in    = down_ff;
      build_held = held_ff;
      held_in    = held_ff;
      accepted   = 1'b0;
      if (exec) begin
         unique case (in_kind_ff)
            hidkm_pkg::REQ_REPORT: begin
               held_in.modifiers = in_mod_ff;
               held_in.usages    = in_slots_ff;
            end
            hidkm_pkg::REQ_TICK: begin
               if (busy_now) begin
                  phase_in = phase_dec;
                  if (phase_dec == 4'd0) begin
                     if (down_ff) begin
                        down_in  = 1'b0;
                        phase_in = gap_ff;
                        head_in  = head_inc;
                     end else if (head_ff != tail_ff) begin
                        down_in  = 1'b1;
                        phase_in = hold_ff;
                     end
                  end
                  build_held = '0;
                  if (down_in) begin
                     build_held.modifiers = head_data_ff[7] ? hidkm_pkg::MOD_LEFT_SHIFT
                                                            : 8'h00;
                     build_held.usages[0] = {1'b0, head_data_ff[6:0]};
                  end
                  held_in = build_held;
               end
            end
            hidkm_pkg::REQ_READ: ;
            hidkm_pkg::REQ_TYPE: begin
               if (q_write) begin
                  tail_in  = tail_inc;
                  accepted = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   hidkm_matrix_build u_build (
      .held (build_held),
      .rows (build_rows)
   );

   always_comb begin
      read_and = hidkm_pkg::ROW_IDLE;
      for (int i = 0; i < hidkm_pkg::MATRIX_ROWS; i++) begin
         if (!in_addr_ff[i]) begin
            read_and = read_and & rows_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         phase_ff <= 4'd0;
         down_ff  <= 1'b0;
         for (int r = 0; r < hidkm_pkg::MATRIX_ROWS; r++) begin
            rows_ff[r] <= hidkm_pkg::ROW_IDLE;
         end
      end else begin
         held_ff  <= held_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         phase_ff <= phase_in;
         down_ff  <= down_in;
         if (exec && in_kind_ff == hidkm_pkg::REQ_TICK) begin
            rows_ff <= build_rows;
         end
      end
   end

   // Queue memory with a registered read that follows the next head pointer.
   always_ff @(posedge clock) begin
      if (q_write) begin
         queue_mem[tail_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (q_write && tail_ff == head_in) begin
         head_data_ff <= q_wdata;
      end else begin
         head_data_ff <= queue_mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec || (rsp_valid_ff && !rsp_ch.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         read_data_ff <= (in_kind_ff == hidkm_pkg::REQ_READ) ? read_and
                                                              : hidkm_pkg::ROW_IDLE;
         accepted_ff  <= accepted;
         busy_ff      <= (head_in != tail_in) || down_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.read_data     = read_data_ff;
   assign rsp_ch.char_accepted = accepted_ff;
   assign rsp_ch.typing_busy   = busy_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hidkm_checks.sv -----
// Port-level assertions for hid_report_to_key_matrix, attached with a bind.
// Depends on the top level's channel interfaces only through the bind connections.
`default_nettype none

module hidkm_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [4:0] read_data,
   input wire logic       char_accepted,
   input wire logic       typing_busy
);

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
         && $stable(char_accepted) && $stable(typing_busy))
      else $error("stalled response changed");

   // Reset empties the response register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The request side only back-pressures when the response side is full and stalled.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

   // A queued character leaves typing busy and is never a port read.
   a_char_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && char_accepted |-> typing_busy && read_data == 5'h1F)
      else $error("accepted character without busy typing");

   // The request valid is only observed here to keep the view of both channels.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$isunknown(req_ready))
      else $error("request ready unknown after a transaction");

endmodule

bind hid_report_to_key_matrix hidkm_checks u_hidkm_checks (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .read_data     (rsp_ch.read_data),
   .char_accepted (rsp_ch.char_accepted),
   .typing_busy   (rsp_ch.typing_busy)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for hid_report_to_key_matrix: sends reports, frame ticks, port reads and typed
// characters, and compares each response with an in-bench model of matrix and typing queue.
// Depends on hidkm_pkg, the channel interfaces in hidkm_channels.sv and the block itself.

module tb;

   localparam int QDEPTH         = 64;
   localparam int STALL_LIMIT    = 3000;
   localparam int HOLDOFF_CYCLES = 250;

   typedef struct packed {
      hidkm_pkg::req_kind_type              kind;
      logic [7:0]                           modifiers;
      logic [hidkm_pkg::KEY_SLOTS-1:0][7:0] slots;
      logic [7:0]                           high_addr;
      logic [7:0]                           char_code;
   } key_req_type;

   typedef struct packed {
      logic [4:0] read_data;
      logic       accepted;
      logic       busy;
   } key_rsp_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [hidkm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [hidkm_pkg::CSR_DATA_W-1:0] csr_wdata;

   hidkm_req_if req_if ();
   hidkm_rsp_if rsp_if ();

   hid_report_to_key_matrix u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state: matrix, held report, typing queue and frame counts.
   hidkm_pkg::row_type mx_rows [hidkm_pkg::MATRIX_ROWS];
   logic [7:0]         mx_mods;
   logic [7:0]         mx_usages [hidkm_pkg::KEY_SLOTS];
   logic [6:0]         tq_usage [QDEPTH];
   logic               tq_shift [QDEPTH];
   int                 tq_head;
   int                 tq_tail;
   logic [3:0]         tq_phase;
   logic               tq_down;
   logic [3:0]         cfg_hold;
   logic [3:0]         cfg_gap;

   key_rsp_type awaited_rsp [$];
   int          error_count  = 0;
   int          items_sent   = 0;
   int          rsp_count    = 0;
   bit          quiet        = 1'b0;
   int          holdoff_asks = 0;
   int          holdoff_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Entry layout: bits 5:0 row*8+column in octal, 0o100 adds Caps Shift, 0o200 Symbol Shift.
   function automatic logic [7:0] matrix_entry(input logic [7:0] u);
      logic [7:0] e;
      case (u)
         8'h04: e = 8'o010;  8'h05: e = 8'o074;  8'h06: e = 8'o003;  8'h07: e = 8'o012;
         8'h08: e = 8'o022;  8'h09: e = 8'o013;  8'h0A: e = 8'o014;  8'h0B: e = 8'o064;
         8'h0C: e = 8'o052;  8'h0D: e = 8'o063;  8'h0E: e = 8'o062;  8'h0F: e = 8'o061;
         8'h10: e = 8'o072;  8'h11: e = 8'o073;  8'h12: e = 8'o051;  8'h13: e = 8'o050;
         8'h14: e = 8'o020;  8'h15: e = 8'o023;  8'h16: e = 8'o011;  8'h17: e = 8'o024;
         8'h18: e = 8'o053;  8'h19: e = 8'o004;  8'h1A: e = 8'o021;  8'h1B: e = 8'o002;
         8'h1C: e = 8'o054;  8'h1D: e = 8'o001;  8'h1E: e = 8'o030;  8'h1F: e = 8'o031;
         8'h20: e = 8'o032;  8'h21: e = 8'o033;  8'h22: e = 8'o034;  8'h23: e = 8'o044;
         8'h24: e = 8'o043;  8'h25: e = 8'o042;  8'h26: e = 8'o041;  8'h27: e = 8'o040;
         8'h28: e = 8'o060;  8'h2C: e = 8'o070;
         8'h2A: e = 8'o140;  8'h4C: e = 8'o140;  8'h50: e = 8'o134;  8'h51: e = 8'o144;
         8'h52: e = 8'o143;  8'h4F: e = 8'o142;  8'h29: e = 8'o170;
         8'h33: e = 8'o251;  8'h34: e = 8'o243;  8'h36: e = 8'o273;  8'h37: e = 8'o272;
         8'h38: e = 8'o204;  8'h2D: e = 8'o263;  8'h2E: e = 8'o261;
         default: e = 8'o000;
      endcase
      return e;
   endfunction

   function automatic logic ascii_to_usage(input logic [7:0] c, output logic [7:0] u,
                                           output logic caps);
      caps = 1'b0;
      u = 8'h00;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'h5D;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         u = c - 8'h3D;
         caps = 1'b1;
      end else if (c >= 8'h31 && c <= 8'h39) begin
         u = c - 8'h13;
      end else begin
         case (c)
            8'h30: u = 8'h27;
            8'h20: u = 8'h2C;
            8'h0A: u = 8'h28;
            8'h3B: u = 8'h33;
            8'h27: u = 8'h34;
            8'h2C: u = 8'h36;
            8'h2E: u = 8'h37;
            8'h2F: u = 8'h38;
            8'h2D: u = 8'h2D;
            8'h3D: u = 8'h2E;
            default: u = 8'h00;
         endcase
      end
      return u != 8'h00;
   endfunction

   function automatic void press_key(input logic [5:0] k);
      mx_rows[k[5:3]][k[2:0]] = 1'b0;
   endfunction

   function automatic void rebuild_matrix();
      logic [7:0] e;
      foreach (mx_rows[r]) mx_rows[r] = hidkm_pkg::ROW_IDLE;
      if ((mx_mods & hidkm_pkg::MOD_SHIFT_MASK) != 8'h00) press_key(hidkm_pkg::KEY_CAPS);
      if ((mx_mods & hidkm_pkg::MOD_CTRL_MASK) != 8'h00) press_key(hidkm_pkg::KEY_SYM);
      for (int i = 0; i < hidkm_pkg::KEY_SLOTS; i++) begin
         e = matrix_entry(mx_usages[i]);
         if (e[5:0] != 6'o00) begin
            press_key(e[5:0]);
            if (e[hidkm_pkg::ENTRY_CAPS_BIT]) press_key(hidkm_pkg::KEY_CAPS);
            if (e[hidkm_pkg::ENTRY_SYM_BIT]) press_key(hidkm_pkg::KEY_SYM);
         end
      end
   endfunction

   function automatic bit typing_pending();
      return (tq_head != tq_tail) || tq_down;
   endfunction

   // While typing is pending, a frame tick replaces the held report with the typed key.
   function automatic void advance_frame();
      if (typing_pending()) begin
         if (tq_phase != 4'd0) tq_phase--;
         if (tq_phase == 4'd0) begin
            if (tq_down) begin
               tq_down  = 1'b0;
               tq_phase = cfg_gap;
               tq_head  = (tq_head + 1) % QDEPTH;
            end else if (tq_head != tq_tail) begin
               tq_down  = 1'b1;
               tq_phase = cfg_hold;
            end
         end
         mx_mods = 8'h00;
         foreach (mx_usages[i]) mx_usages[i] = 8'h00;
         if (tq_down && tq_head != tq_tail) begin
            mx_mods      = tq_shift[tq_head] ? hidkm_pkg::MOD_LEFT_SHIFT : 8'h00;
            mx_usages[0] = {1'b0, tq_usage[tq_head]};
         end
      end
      rebuild_matrix();
   endfunction

   function automatic void model_reset();
      foreach (mx_rows[r]) mx_rows[r] = hidkm_pkg::ROW_IDLE;
      foreach (mx_usages[i]) mx_usages[i] = 8'h00;
      foreach (tq_usage[i]) begin
         tq_usage[i] = 7'h00;
         tq_shift[i] = 1'b0;
      end
      mx_mods  = 8'h00;
      tq_head  = 0;
      tq_tail  = 0;
      tq_phase = 4'd0;
      tq_down  = 1'b0;
      cfg_hold = hidkm_pkg::HOLD_FRAMES_RESET;
      cfg_gap  = hidkm_pkg::GAP_FRAMES_RESET;
   endfunction

   function automatic key_rsp_type predict_response(input key_req_type it);
      key_rsp_type r;
      logic [7:0]  u;
      logic        caps;
      int          nxt;
      r.read_data = hidkm_pkg::ROW_IDLE;
      r.accepted  = 1'b0;
      case (it.kind)
         hidkm_pkg::REQ_REPORT: begin
            mx_mods = it.modifiers;
            for (int i = 0; i < hidkm_pkg::KEY_SLOTS; i++) mx_usages[i] = it.slots[i];
         end
         hidkm_pkg::REQ_TICK: advance_frame();
         hidkm_pkg::REQ_READ: begin
            for (int i = 0; i < hidkm_pkg::MATRIX_ROWS; i++)
               if (!it.high_addr[i]) r.read_data &= mx_rows[i];
         end
         hidkm_pkg::REQ_TYPE: begin
            if (ascii_to_usage(it.char_code, u, caps)) begin
               nxt = (tq_tail + 1) % QDEPTH;
               if (nxt != tq_head) begin
                  tq_usage[tq_tail] = u[6:0];
                  tq_shift[tq_tail] = caps;
                  tq_tail    = nxt;
                  r.accepted = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.busy = typing_pending();
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) $display("tb: mismatch at %0t: %s", $time, what);
   endtask

   // Every field is random unless the caller overrides it, so unused bits toggle too.
   function automatic key_req_type make_item(input hidkm_pkg::req_kind_type kind);
      key_req_type it;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = $urandom;
      b = $urandom;
      c = $urandom;
      it.kind      = kind;
      it.modifiers = a[7:0];
      it.slots     = {a[31:16], b};
      it.high_addr = c[7:0];
      it.char_code = c[15:8];
      return it;
   endfunction

   // Called and returns at a falling edge; valid stays high so the next item can follow.
   task automatic send_item(input key_req_type it);
      if (!quiet) begin
         while ($urandom_range(99) < 30) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid         = 1'b1;
      req_if.req_type      = it.kind;
      req_if.modifier_bits = it.modifiers;
      req_if.key_slot_0    = it.slots[0];
      req_if.key_slot_1    = it.slots[1];
      req_if.key_slot_2    = it.slots[2];
      req_if.key_slot_3    = it.slots[3];
      req_if.key_slot_4    = it.slots[4];
      req_if.key_slot_5    = it.slots[5];
      req_if.high_addr     = it.high_addr;
      req_if.char_code     = it.char_code;
      do @(posedge clock); while (!req_if.ready);
      awaited_rsp.push_back(predict_response(it));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_report(input logic [7:0] mods,
                              input logic [hidkm_pkg::KEY_SLOTS-1:0][7:0] keys);
      key_req_type it;
      it = make_item(hidkm_pkg::REQ_REPORT);
      it.modifiers = mods;
      it.slots     = keys;
      send_item(it);
   endtask

   task automatic send_tick();
      send_item(make_item(hidkm_pkg::REQ_TICK));
   endtask

   task automatic send_read(input logic [7:0] addr);
      key_req_type it;
      it = make_item(hidkm_pkg::REQ_READ);
      it.high_addr = addr;
      send_item(it);
   endtask

   task automatic send_char(input logic [7:0] c);
      key_req_type it;
      it = make_item(hidkm_pkg::REQ_TYPE);
      it.char_code = c;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure_frames(input logic [3:0] hold, input logic [3:0] gap);
      wait_drained();
      csr_we    = 1'b1;
      csr_index = hidkm_pkg::CSR_HOLD_FRAMES;
      csr_wdata = hold;
      @(negedge clock);
      csr_index = hidkm_pkg::CSR_GAP_FRAMES;
      csr_wdata = gap;
      @(negedge clock);
      csr_we   = 1'b0;
      cfg_hold = hold;
      cfg_gap  = gap;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_usage();
      logic [31:0] v;
      int          r;
      r = $urandom_range(99);
      v = $urandom;
      if (r < 60) v = $urandom_range(32'h38, 32'h04);
      else if (r < 70) v = 32'h4F + $urandom_range(3);
      else if (r < 75) v = 32'h4C;
      else if (r < 85) v = 32'h00;
      return v[7:0];
   endfunction

   function automatic logic [hidkm_pkg::KEY_SLOTS-1:0][7:0] pick_keys();
      logic [hidkm_pkg::KEY_SLOTS-1:0][7:0] k;
      for (int i = 0; i < hidkm_pkg::KEY_SLOTS; i++)
         k[i] = ($urandom_range(99) < 40) ? 8'h00 : pick_usage();
      return k;
   endfunction

   function automatic logic [7:0] pick_mods();
      logic [31:0] v;
      int          r;
      r = $urandom_range(99);
      v = $urandom;
      if (r < 30) v = 32'h00;
      else if (r < 40) v = v & 32'h22;
      else if (r < 50) v = v & 32'h11;
      return v[7:0];
   endfunction

   function automatic logic [7:0] pick_addr();
      logic [31:0] v;
      int          r;
      r = $urandom_range(99);
      v = $urandom;
      if (r < 50) v = ~(32'h1 << $urandom_range(7));
      else if (r < 58) v = 32'h00;
      else if (r < 63) v = 32'hFF;
      return v[7:0];
   endfunction

   function automatic logic [7:0] pick_char(input logic allow_reject);
      logic [31:0] v;
      int          r;
      r = $urandom_range(99);
      v = $urandom;
      if (!allow_reject) begin
         if (r < 35) v = 32'h61 + $urandom_range(25);
         else if (r < 55) v = 32'h41 + $urandom_range(25);
         else if (r < 70) v = 32'h30 + $urandom_range(9);
         else begin
            case ($urandom_range(9))
               0: v = 32'h20;
               1: v = 32'h0A;
               2: v = 32'h3B;
               3: v = 32'h27;
               4: v = 32'h2C;
               5: v = 32'h2E;
               6: v = 32'h2F;
               7: v = 32'h2D;
               default: v = 32'h3D;
            endcase
         end
      end
      return v[7:0];
   endfunction

   // Tick until the queue and the key that is down are both done, with reads in between.
   task automatic replay_typing();
      while (typing_pending()) begin
         send_tick();
         if ($urandom_range(99) < 15) send_read(pick_addr());
      end
   endtask

   task automatic test_key_matrix_directed();
      send_read(8'h00);
      send_report(8'hFF, {8'h00, 8'h2B, 8'h67, 8'h68, 8'hFF, 8'h04});
      // A report on its own must leave the matrix untouched until the next tick.
      send_read(8'h00);
      send_tick();
      send_read(8'h00);
      send_read(8'hFE);
      send_read(8'h7F);
      send_read(8'hFF);
      send_report(8'h00, {8'h2E, 8'h50, 8'h38, 8'h29, 8'h33, 8'h2A});
      send_tick();
      send_read(8'hEF);
      send_read(8'h00);
      send_report(8'h00, '0);
      send_tick();
      send_read(8'h00);
   endtask

   task automatic test_typing_directed();
      send_char(8'h61);
      send_char(8'h5A);
      send_char(8'h0A);
      send_char(8'h3D);
      send_char(8'h21);
      send_char(8'h80);
      send_char(8'hFF);
      replay_typing();
   endtask

   // The receiver holds off while characters keep coming, so the block backs up and
   // stalls its input; the queue overflows and the last characters are turned away.
   task automatic test_queue_full_holdoff();
      holdoff_asks++;
      for (int n = 0; n < QDEPTH + 2; n++) send_char(pick_char(1'b0));
      wait_drained();
      replay_typing();
   endtask

   task automatic test_random_traffic(input int n_items);
      int          stop_at;
      int          len;
      int          r;
      logic [31:0] rnd;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 35) begin
            len = (cfg_hold + cfg_gap > 10) ? 1 : $urandom_range(4, 1);
            repeat (len) send_char(pick_char($urandom_range(99) < 15));
            // A report sent while typing is pending must be overridden at the next tick.
            if ($urandom_range(99) < 20) send_report(pick_mods(), pick_keys());
            replay_typing();
            repeat ($urandom_range(2)) send_tick();
         end else if (r < 70) begin
            send_report(pick_mods(), pick_keys());
            if ($urandom_range(99) < 30) send_read(pick_addr());
            send_tick();
            repeat ($urandom_range(3, 1)) send_read(pick_addr());
         end else if (r < 85) begin
            send_read(pick_addr());
         end else begin
            rnd = $urandom;
            send_item(make_item(hidkm_pkg::req_kind_type'(rnd[1:0])));
         end
         if ($urandom_range(99) < 5) wait_drained();
      end
   endtask

   task automatic test_back_to_back(input int n_items);
      quiet = 1'b1;
      test_random_traffic(n_items);
      quiet = 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] rnd;
      req_if.valid         = 1'b0;
      req_if.req_type      = hidkm_pkg::REQ_REPORT;
      req_if.modifier_bits = 8'h00;
      req_if.key_slot_0    = 8'h00;
      req_if.key_slot_1    = 8'h00;
      req_if.key_slot_2    = 8'h00;
      req_if.key_slot_3    = 8'h00;
      req_if.key_slot_4    = 8'h00;
      req_if.key_slot_5    = 8'h00;
      req_if.high_addr     = 8'hFF;
      req_if.char_code     = 8'h00;
      csr_we    = 1'b0;
      csr_index = hidkm_pkg::CSR_HOLD_FRAMES;
      csr_wdata = '0;
      reset     = 1'b1;
      model_reset();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_key_matrix_directed();
      configure_frames(4'd1, 4'd1);
      test_typing_directed();
      test_queue_full_holdoff();
      configure_frames(4'd0, 4'd0);
      test_random_traffic(15);
      configure_frames(4'd15, 4'd15);
      test_random_traffic(15);
      configure_frames(4'd1, 4'd15);
      test_random_traffic(15);
      configure_frames(4'd15, 4'd1);
      test_random_traffic(15);
      configure_frames(hidkm_pkg::HOLD_FRAMES_RESET, hidkm_pkg::GAP_FRAMES_RESET);
      test_back_to_back(15);
      rnd = $urandom;
      configure_frames(rnd[3:0], rnd[7:4]);
      test_random_traffic(15);

      wait_drained();
      repeat (8) @(negedge clock);
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   // The receiver counts its own hold-off when the stimulus asks for one.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_asks != holdoff_seen) begin
            holdoff_seen = holdoff_asks;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = quiet || ($urandom_range(99) >= 30);
         end
      end
   end

   always @(posedge clock) begin
      key_rsp_type got;
      key_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.read_data, rsp_if.char_accepted, rsp_if.typing_busy};
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("response %0d with none expected: data %h acc %b busy %b",
                                      rsp_count, got.read_data, got.accepted, got.busy));
         end else begin
            want = awaited_rsp.pop_front();
            if (got.read_data !== want.read_data)
               report_mismatch($sformatf("response %0d read_data %h, expected %h",
                                         rsp_count, got.read_data, want.read_data));
            if (got.accepted !== want.accepted)
               report_mismatch($sformatf("response %0d char_accepted %b, expected %b",
                                         rsp_count, got.accepted, want.accepted));
            if (got.busy !== want.busy)
               report_mismatch($sformatf("response %0d typing_busy %b, expected %b",
                                         rsp_count, got.busy, want.busy));
         end
         rsp_count++;
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb: errors");
      $finish;
   end

endmodule
